### sv/gcbs_pkg.sv
// Shared types and constants for the glyph code binary search unit.
// No dependencies; every other file but gcbs_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none

package gcbs_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;  // default number of table slots
  localparam int SLOT_W          = 12;    // slot_index / glyph_index width
  localparam int CODE_W          = 16;    // character code width
  localparam int COUNT_CFG_W     = 13;    // entry_count register width
  localparam int QUEUE_DEPTH     = 2;     // words held between front and back

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // One classified word as it travels from front to back.
  typedef struct packed {
    cmd_e                cmd;
    logic [SLOT_W-1:0]   slot;
    logic [CODE_W-1:0]   code;
  } entry_t;

endpackage

`default_nettype wire

### sv/gcbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gcbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/gcbs_fifo.sv
// Short word queue between the front and back parts.
// Depends on gcbs_pkg (entry_t).
`timescale 1ns / 1ps
`default_nettype none

module gcbs_fifo #(
  parameter int DEPTH = gcbs_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  gcbs_pkg::entry_t      push_data_i,
  input  wire logic             pop_i,
  output gcbs_pkg::entry_t      head_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import gcbs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### sv/gcbs_front.sv
// Front part: takes command words, drops writes aimed past the table,
// and hands the rest to the queue. Depends on gcbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcbs_front #(
  parameter int TABLE_DEPTH = gcbs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         start_i,
  input  wire logic                         cmd_i,
  input  wire logic [gcbs_pkg::SLOT_W-1:0]  slot_index_i,
  input  wire logic [gcbs_pkg::CODE_W-1:0]  code_point_i,
  input  wire logic                         full_i,
  output logic                              busy_o,
  output logic                              push_o,
  output gcbs_pkg::entry_t                  entry_o
);
  import gcbs_pkg::*;

  logic        accept;
  logic        is_lookup;
  logic [31:0] slot_ext;
  logic        slot_in_range;

  assign busy_o        = full_i;
  assign accept        = start_i && !full_i;
  assign is_lookup     = (cmd_e'(cmd_i) == CMD_LOOKUP);
  assign slot_ext      = 32'(slot_index_i);
  assign slot_in_range = (slot_ext < 32'(TABLE_DEPTH));

  // A write outside the table changes nothing, so it never reaches the back.
  assign push_o        = accept && (is_lookup || slot_in_range);

  assign entry_o.cmd  = cmd_e'(cmd_i);
  assign entry_o.slot = slot_index_i;
  assign entry_o.code = code_point_i;

endmodule

`default_nettype wire

### sv/gcbs_back.sv
// Back part: performs table writes and the binary search, one probe per cycle.
// Depends on gcbs_pkg and gcbs_ram.
`timescale 1ns / 1ps
`default_nettype none

module gcbs_back #(
  parameter int TABLE_DEPTH = gcbs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]  count_i,
  input  gcbs_pkg::entry_t                       head_i,
  input  wire logic                              empty_i,
  output logic                                   pop_o,
  output logic                                   done_o,
  output logic      [gcbs_pkg::SLOT_W-1:0]       glyph_index_o,
  output logic                                   found_o
);
  import gcbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       lo_q, lo_d;      // lowest candidate slot
  logic [CW-1:0]       hx_q, hx_d;      // one past highest candidate slot
  logic [AW-1:0]       mid_q, mid_d;    // slot whose data arrives this cycle
  logic [CODE_W-1:0]   key_q, key_d;
  logic                done_q, done_d;
  logic                found_q, found_d;
  logic [SLOT_W-1:0]   index_q, index_d;

  logic [CODE_W-1:0]   rdata;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         slot_ext, mid_ext;
  logic [CW-1:0]       lo_n, hx_n;
  logic [CW:0]         mid_sum;
  logic [AW-1:0]       next_mid;
  logic                more;
  logic                probe_eq, probe_lt;

  assign slot_ext  = 32'(head_i.slot);
  assign mid_ext   = 32'(mid_q);
  assign ram_waddr = slot_ext[AW-1:0];
  assign probe_eq  = (rdata == key_q);
  assign probe_lt  = (rdata < key_q);

  // Open the window in idle, else narrow it by the probe, then pick the midpoint.
  always_comb begin
    if (state_q == S_IDLE) begin
      lo_n = '0;
      hx_n = count_i;
    end else if (probe_lt) begin
      lo_n = CW'(mid_q) + 1'b1;
      hx_n = hx_q;
    end else begin
      lo_n = lo_q;
      hx_n = CW'(mid_q);
    end
    more     = (lo_n < hx_n);
    mid_sum  = {1'b0, lo_n} + {1'b0, hx_n} - 1'b1;
    next_mid = mid_sum[AW:1];
  end

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hx_d    = hx_q;
    mid_d   = mid_q;
    key_d   = key_q;
    done_d  = 1'b0;
    found_d = 1'b0;
    index_d = '0;
    pop_o   = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (head_i.cmd)
            CMD_WRITE: begin
              ram_we = 1'b1;
            end
            CMD_LOOKUP: begin
              key_d = head_i.code;
              if (more) begin
                ram_re  = 1'b1;
                lo_d    = lo_n;
                hx_d    = hx_n;
                mid_d   = next_mid;
                state_d = S_SEARCH;
              end else begin
                done_d = 1'b1;  // empty table: nothing to probe
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (probe_eq) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          index_d = mid_ext[SLOT_W-1:0];
          state_d = S_IDLE;
        end else if (more) begin
          ram_re = 1'b1;
          lo_d   = lo_n;
          hx_d   = hx_n;
          mid_d  = next_mid;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lo_q    <= '0;
      hx_q    <= '0;
      mid_q   <= '0;
      key_q   <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      index_q <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hx_q    <= hx_d;
      mid_q   <= mid_d;
      key_q   <= key_d;
      done_q  <= done_d;
      found_q <= found_d;
      index_q <= index_d;
    end
  end

  gcbs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (head_i.code),
    .re_i    (ram_re),
    .raddr_i (next_mid),
    .rdata_o (rdata)
  );

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign glyph_index_o = index_q;

endmodule

`default_nettype wire

### sv/glyph_code_binary_search_unit.sv
// Top level of the glyph code binary search unit: entry_count register, front part,
// word queue and back part. Depends on gcbs_pkg, gcbs_front, gcbs_fifo, gcbs_back.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a table of 16-bit character codes (software keeps it sorted) and
// answers lookups by binary search over slots 0 .. entry_count-1. A word is
// taken when start_i is high and busy_o low; cmd_i = 0 writes code_point_i
// into slot slot_index_i (writes past the table are dropped) and gives no
// result, cmd_i = 1 searches for code_point_i. Each lookup gives exactly one
// result, shown on glyph_index_o / found_o for the single cycle that done_o
// is high; there is no way to hold it, so the receiver must take it then.
// Flow: a two-word queue sits between the front and the search engine, so
// busy_o only rises when two words are waiting. The engine works on one word
// at a time. A lookup is launched as it leaves the queue and makes at most
// floor(log2(entry_count)) + 1 probes (13 for a full 4096-slot table);
// done_o follows the last probe, and the probes are paced by the table RAM's
// registered read port, which delivers one probe per cycle.
// entry_count_i is taken when entry_count_we_i is high and is clipped to
// TABLE_DEPTH; write it only while no lookup is pending. Table contents are
// not cleared by reset: only slots already written may be searched.

module glyph_code_binary_search_unit #(
  parameter int TABLE_DEPTH = gcbs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command words
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic                              cmd_i,
  input  wire logic [gcbs_pkg::SLOT_W-1:0]       slot_index_i,
  input  wire logic [gcbs_pkg::CODE_W-1:0]       code_point_i,
  // results
  output logic                                   done_o,
  output logic      [gcbs_pkg::SLOT_W-1:0]       glyph_index_o,
  output logic                                   found_o,
  // configuration
  input  wire logic                              entry_count_we_i,
  input  wire logic [gcbs_pkg::COUNT_CFG_W-1:0]  entry_count_i
);
  import gcbs_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          q_full, q_empty, q_push, q_pop;
  entry_t        q_in, q_head;

  // Clip at write time so the search never sees a count past the table.
  always_comb begin
    count_d = count_q;
    if (entry_count_we_i) begin
      if (32'(entry_count_i) > 32'(TABLE_DEPTH)) begin
        count_d = CW'(TABLE_DEPTH);
      end else begin
        count_d = CW'(entry_count_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  gcbs_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .slot_index_i (slot_index_i),
    .code_point_i (code_point_i),
    .full_i       (q_full),
    .busy_o       (busy_o),
    .push_o       (q_push),
    .entry_o      (q_in)
  );

  gcbs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  gcbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .count_i       (count_q),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .done_o        (done_o),
    .glyph_index_o (glyph_index_o),
    .found_o       (found_o)
  );

endmodule

`default_nettype wire

### sv/gcbs_checker.sv
// Port-level assertions for glyph_code_binary_search_unit, bound to the top level.
// Depends on gcbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcbs_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start_i,
  input wire logic                              busy_o,
  input wire logic                              done_o,
  input wire logic [gcbs_pkg::SLOT_W-1:0]       glyph_index_o,
  input wire logic                              found_o
);

  // found is only ever raised together with the strobe
  a_found_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> done_o)
    else $error("found_o high without done_o");

  // a miss always reports slot zero
  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (glyph_index_o == '0))
    else $error("miss reported with nonzero glyph_index_o");

  // the queue only fills up because a word was just taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy_o rose without a preceding start_i");

  // once reset has been seen at an edge, nothing is reported on the next one
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> (!done_o && !busy_o))
    else $error("outputs active during reset");

endmodule

bind glyph_code_binary_search_unit gcbs_checker u_gcbs_checker (.*);

`default_nettype wire
